FILE: rtl/matrix_add_sub_multiply_unit_top_assert.svh
// Assertion macros for the matrix add/sub/multiply unit.
// Used by matrix_add_sub_multiply_unit_top; no other dependencies.
`ifndef MATRIX_ADD_SUB_MULTIPLY_UNIT_TOP_ASSERT_SVH
`define MATRIX_ADD_SUB_MULTIPLY_UNIT_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MAS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("matrix unit assertion failed");

// next-cycle implication, off during reset
`define MAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("matrix unit assertion failed");

`endif

FILE: rtl/masmu_pkg.sv
// Shared types and constants for the matrix add/sub/multiply unit.
// No dependencies.
`timescale 1ns / 1ps

package masmu_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // input operation codes
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // op_mode codes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_A_ROWS  = 3'd0;
    localparam logic [2:0] REG_A_COLS  = 3'd1;
    localparam logic [2:0] REG_B_ROWS  = 3'd2;
    localparam logic [2:0] REG_B_COLS  = 3'd3;
    localparam logic [2:0] REG_OP_MODE = 3'd4;

    typedef struct packed {
        logic [1:0]          operation;
        logic [2:0]          row_index;
        logic [2:0]          col_index;
        logic signed [31:0]  element_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          out_row;
        logic [2:0]          out_col;
        logic signed [31:0]  result_value;
        logic                size_error;
        logic                last;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_LOAD_A,
        KIND_LOAD_B,
        KIND_COMPUTE,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] rows_m1;
        logic [2:0] cols_m1;
        logic [2:0] inner_m1;
    } shape_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        shape_t      shape;
    } entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QLVL_W-1:0] level;
    } fifo_stat_t;

endpackage

FILE: rtl/masmu_front.sv
// Front end: configuration registers, item classification and shape check.
// Depends on masmu_pkg.
`timescale 1ns / 1ps

module masmu_front #(
    parameter int MAX_DIM = masmu_pkg::MAX_DIM_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [3:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  masmu_pkg::in_item_t  s_data,
    input  logic                 q_full,
    output logic                 q_push,
    output masmu_pkg::entry_t    q_entry
);
    import masmu_pkg::*;

    logic [3:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [1:0] op_mode_reg;
    logic       dims_ok, shape_ok, in_range, is_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg  <= 4'd1;
            a_cols_reg  <= 4'd1;
            b_rows_reg  <= 4'd1;
            b_cols_reg  <= 4'd1;
            op_mode_reg <= MODE_ADD;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_A_ROWS:  a_rows_reg  <= cfg_data;
                REG_A_COLS:  a_cols_reg  <= cfg_data;
                REG_B_ROWS:  b_rows_reg  <= cfg_data;
                REG_B_COLS:  b_cols_reg  <= cfg_data;
                REG_OP_MODE: op_mode_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        dims_ok = (a_rows_reg != 4'd0) && (a_rows_reg <= 4'(MAX_DIM))
               && (a_cols_reg != 4'd0) && (a_cols_reg <= 4'(MAX_DIM))
               && (b_rows_reg != 4'd0) && (b_rows_reg <= 4'(MAX_DIM))
               && (b_cols_reg != 4'd0) && (b_cols_reg <= 4'(MAX_DIM));
        case (op_mode_reg)
            MODE_ADD, MODE_SUB:
                shape_ok = dims_ok && (a_rows_reg == b_rows_reg)
                        && (a_cols_reg == b_cols_reg);
            MODE_MUL: shape_ok = dims_ok && (a_cols_reg == b_rows_reg);
            default:  shape_ok = 1'b0;
        endcase

        in_range = ({1'b0, s_data.row_index} < 4'(MAX_DIM))
                && ({1'b0, s_data.col_index} < 4'(MAX_DIM));
        is_load  = (s_data.operation == OP_LOAD_A) || (s_data.operation == OP_LOAD_B);

        q_entry.row            = s_data.row_index;
        q_entry.col            = s_data.col_index;
        q_entry.value          = s_data.element_value;
        q_entry.shape.mode     = op_mode_reg;
        q_entry.shape.rows_m1  = 3'(a_rows_reg - 4'd1);
        q_entry.shape.cols_m1  = (op_mode_reg == MODE_MUL) ? 3'(b_cols_reg - 4'd1)
                                                           : 3'(a_cols_reg - 4'd1);
        q_entry.shape.inner_m1 = 3'(a_cols_reg - 4'd1);
        case (s_data.operation)
            OP_LOAD_A: q_entry.kind = KIND_LOAD_A;
            OP_LOAD_B: q_entry.kind = KIND_LOAD_B;
            default:   q_entry.kind = shape_ok ? KIND_COMPUTE : KIND_ERROR;
        endcase
    end

    // out-of-range loads and operation code 3 are taken and dropped
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full
                  && ((is_load && in_range) || (s_data.operation == OP_COMPUTE));

endmodule

FILE: rtl/masmu_queue.sv
// Short queue of classified items between front and back end.
// Depends on masmu_pkg.
`timescale 1ns / 1ps

module masmu_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  masmu_pkg::entry_t      push_entry,
    input  logic                   pop,
    output masmu_pkg::entry_t      head,
    output masmu_pkg::fifo_stat_t  stat
);
    import masmu_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0]   level_reg;
    logic                do_push, do_pop;

    assign stat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/masmu_back.sv
// Back end: A and B stores, element sequencer, multiply-accumulate pipeline
// and output register. Depends on masmu_pkg.
`timescale 1ns / 1ps

module masmu_back #(
    parameter int MAX_DIM = masmu_pkg::MAX_DIM_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  masmu_pkg::entry_t     q_entry,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output masmu_pkg::out_item_t  m_data
);
    import masmu_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       first;
        logic       lastk;
        logic       last;
        logic       err;
        logic [1:0] mode;
    } beat_t;

    function automatic logic [ADDR_W-1:0] st_addr(input logic [2:0] r, input logic [2:0] c);
        st_addr = ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    state_t      state_reg;
    logic [2:0]  i_reg, j_reg, k_reg;
    shape_t      shape_reg;
    logic        err_reg;

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];

    logic        s1_valid_reg, s2_valid_reg, out_valid_reg;
    beat_t       s1_beat_reg, s2_beat_reg;
    logic [31:0] rd_a_reg, rd_b_reg, s2_val_reg, acc_reg;
    out_item_t   out_reg;

    logic              adv, issue;
    beat_t             beat;
    logic [ADDR_W-1:0] addr_a, addr_b, wr_addr;
    logic [31:0]       s2_val_next, acc_next;

    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && (state_reg == ST_IDLE) && q_valid;
    assign issue = adv && (state_reg == ST_RUN);

    always_comb begin
        beat.row   = i_reg;
        beat.col   = j_reg;
        beat.first = (k_reg == 3'd0);
        beat.lastk = err_reg || (shape_reg.mode != MODE_MUL) || (k_reg == shape_reg.inner_m1);
        beat.last  = beat.lastk && (i_reg == shape_reg.rows_m1)
                  && (j_reg == shape_reg.cols_m1);
        beat.err   = err_reg;
        beat.mode  = shape_reg.mode;
        if (shape_reg.mode == MODE_MUL) begin
            addr_a = st_addr(i_reg, k_reg);
            addr_b = st_addr(k_reg, j_reg);
        end else begin
            addr_a = st_addr(i_reg, j_reg);
            addr_b = st_addr(i_reg, j_reg);
        end
        wr_addr = st_addr(q_entry.row, q_entry.col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= 1'b0;
            shape_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop && (q_entry.kind == KIND_COMPUTE
                                  || q_entry.kind == KIND_ERROR)) begin
                        state_reg          <= ST_RUN;
                        i_reg              <= '0;
                        j_reg              <= '0;
                        k_reg              <= '0;
                        err_reg            <= (q_entry.kind == KIND_ERROR);
                        shape_reg.mode     <= q_entry.shape.mode;
                        shape_reg.inner_m1 <= q_entry.shape.inner_m1;
                        shape_reg.rows_m1  <= (q_entry.kind == KIND_ERROR)
                                            ? 3'd0 : q_entry.shape.rows_m1;
                        shape_reg.cols_m1  <= (q_entry.kind == KIND_ERROR)
                                            ? 3'd0 : q_entry.shape.cols_m1;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (beat.last) begin
                            state_reg <= ST_IDLE;
                        end else if (beat.lastk) begin
                            k_reg <= '0;
                            if (j_reg == shape_reg.cols_m1) begin
                                j_reg <= '0;
                                i_reg <= i_reg + 3'd1;
                            end else begin
                                j_reg <= j_reg + 3'd1;
                            end
                        end else begin
                            k_reg <= k_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.kind == KIND_LOAD_A) begin
            mem_a[wr_addr] <= q_entry.value;
        end
        if (issue) begin
            rd_a_reg <= mem_a[addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.kind == KIND_LOAD_B) begin
            mem_b[wr_addr] <= q_entry.value;
        end
        if (issue) begin
            rd_b_reg <= mem_b[addr_b];
        end
    end

    always_comb begin
        case (s1_beat_reg.mode)
            MODE_SUB: s2_val_next = rd_a_reg - rd_b_reg;
            MODE_MUL: s2_val_next = 32'(rd_a_reg * rd_b_reg);
            default:  s2_val_next = rd_a_reg + rd_b_reg;
        endcase
        acc_next = s2_beat_reg.first ? s2_val_reg : acc_reg + s2_val_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_beat_reg.lastk;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_beat_reg <= beat;
            s2_beat_reg <= s1_beat_reg;
            s2_val_reg  <= s2_val_next;
            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            out_reg.out_row      <= s2_beat_reg.err ? 3'd0 : s2_beat_reg.row;
            out_reg.out_col      <= s2_beat_reg.err ? 3'd0 : s2_beat_reg.col;
            out_reg.result_value <= s2_beat_reg.err ? 32'sd0 : signed'(acc_next);
            out_reg.size_error   <= s2_beat_reg.err;
            out_reg.last         <= s2_beat_reg.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/matrix_add_sub_multiply_unit_top.sv
// Top level of the matrix add/sub/multiply unit: front end, queue, back end.
// Depends on masmu_pkg, masmu_front, masmu_queue, masmu_back and the assert header.
`timescale 1ns / 1ps
`include "matrix_add_sub_multiply_unit_top_assert.svh"

// Load items (A or B element) are accepted one per cycle while the four-entry
// queue is not full; each is written to its store when the back end pops it. A
// compute item walks the stores through one multiply-accumulate lane that reads
// one A word and one B word per cycle while the output is not stalled: add and
// subtract visit each of the rows*cols results once, multiply sums a_cols
// products per result, and a shape error gives one result. Results come out in
// row-major order through a single output register; the block keeps taking
// items into the queue while a compute runs. Configuration writes are taken in
// any cycle but must only be made while the block is idle.
module matrix_add_sub_multiply_unit_top #(
    parameter int MAX_DIM = masmu_pkg::MAX_DIM_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [3:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  masmu_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output masmu_pkg::out_item_t  m_data
);
    import masmu_pkg::*;

    logic       q_push, q_pop;
    entry_t     q_in, q_head;
    fifo_stat_t fifo_stat;

    masmu_front #(.MAX_DIM(MAX_DIM)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (fifo_stat.full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    masmu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (fifo_stat)
    );

    masmu_back #(.MAX_DIM(MAX_DIM)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (!fifo_stat.empty),
        .q_entry (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `MAS_ASSERT_IMPLY(a_err_result_shape, aclk, aresetn, m_valid && m_data.size_error, m_data.last && m_data.result_value == 32'sd0 && m_data.out_row == 3'd0 && m_data.out_col == 3'd0)
    `MAS_ASSERT_IMPLY(a_queue_level, aclk, aresetn, 1'b1, fifo_stat.level <= QLVL_W'(QUEUE_DEPTH))
    `MAS_ASSERT_NEXT(a_compute_queued, aclk, aresetn, s_valid && s_ready && s_data.operation == OP_COMPUTE, !fifo_stat.empty)

endmodule

FILE: tb/matrix_add_sub_multiply_unit_top_test.sv
// Testbench for matrix_add_sub_multiply_unit_top: directed and random load/compute items
// checked against an in-bench matrix predictor. Depends on masmu_pkg and the RTL.
`timescale 1ns / 1ps

module matrix_add_sub_multiply_unit_top_test;
    import masmu_pkg::*;

    localparam int DIM = MAX_DIM_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 370;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    // predictor state
    logic [31:0] mat_a [0:DIM-1][0:DIM-1];
    logic [31:0] mat_b [0:DIM-1][0:DIM-1];
    logic [3:0] cfg_a_rows = 4'd1;
    logic [3:0] cfg_a_cols = 4'd1;
    logic [3:0] cfg_b_rows = 4'd1;
    logic [3:0] cfg_b_cols = 4'd1;
    logic [1:0] cfg_op_mode = MODE_ADD;
    out_item_t matrix_results_due [$];

    // stimulus state
    in_item_t pending_ops [$];
    bit a_written [0:DIM-1][0:DIM-1];
    bit b_written [0:DIM-1][0:DIM-1];
    int stim_count = 0;
    int items_sent = 0;
    int items_taken = 0;
    bit s_took = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int fail_count = 0;

    matrix_add_sub_multiply_unit_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit shape_fits();
        bit dims_ok;
        dims_ok = cfg_a_rows != 0 && cfg_a_rows <= DIM && cfg_a_cols != 0 && cfg_a_cols <= DIM
                  && cfg_b_rows != 0 && cfg_b_rows <= DIM && cfg_b_cols != 0
                  && cfg_b_cols <= DIM;
        case (cfg_op_mode)
            MODE_ADD, MODE_SUB: return dims_ok && cfg_a_rows == cfg_b_rows
                                       && cfg_a_cols == cfg_b_cols;
            MODE_MUL: return dims_ok && cfg_a_cols == cfg_b_rows;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void apply_matrix_op(in_item_t it);
        out_item_t r;
        logic [31:0] acc;
        int n_rows;
        int n_cols;
        case (it.operation)
            OP_LOAD_A: mat_a[it.row_index][it.col_index] = it.element_value;
            OP_LOAD_B: mat_b[it.row_index][it.col_index] = it.element_value;
            OP_COMPUTE: begin
                r = '0;
                if (!shape_fits()) begin
                    r.size_error = 1'b1;
                    r.last = 1'b1;
                    matrix_results_due.push_back(r);
                end else begin
                    n_rows = cfg_a_rows;
                    n_cols = (cfg_op_mode == MODE_MUL) ? cfg_b_cols : cfg_a_cols;
                    for (int i = 0; i < n_rows; i++) begin
                        for (int j = 0; j < n_cols; j++) begin
                            case (cfg_op_mode)
                                MODE_ADD: acc = mat_a[i][j] + mat_b[i][j];
                                MODE_SUB: acc = mat_a[i][j] - mat_b[i][j];
                                default: begin
                                    acc = '0;
                                    for (int k = 0; k < cfg_a_cols; k++)
                                        acc = acc + mat_a[i][k] * mat_b[k][j];
                                end
                            endcase
                            r.out_row = 3'(i);
                            r.out_col = 3'(j);
                            r.result_value = acc;
                            r.size_error = 1'b0;
                            r.last = (i == n_rows - 1) && (j == n_cols - 1);
                            matrix_results_due.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // input side: record accepted items and predict
    always @(posedge aclk) begin
        s_took = aresetn && s_valid && s_ready;
        if (s_took) begin
            apply_matrix_op(s_data);
            items_taken++;
        end
    end

    always @(negedge aclk) begin
        if (s_valid && !s_took) begin
            // hold the item until taken
        end else if (aresetn && pending_ops.size() != 0
                     && $urandom_range(0, 99) >= send_idle_pct) begin
            s_data <= pending_ops.pop_front();
            s_valid <= 1'b1;
            items_sent++;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (matrix_results_due.size() == 0) begin
                $error("unexpected result: row %0d col %0d value %0d",
                       m_data.out_row, m_data.out_col, m_data.result_value);
                fail_count++;
            end else begin
                want = matrix_results_due.pop_front();
                if (m_data.out_row !== want.out_row) begin
                    $error("out_row: expected %0d, got %0d", want.out_row, m_data.out_row);
                    fail_count++;
                end
                if (m_data.out_col !== want.out_col) begin
                    $error("out_col: expected %0d, got %0d", want.out_col, m_data.out_col);
                    fail_count++;
                end
                if (m_data.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, m_data.result_value);
                    fail_count++;
                end
                if (m_data.size_error !== want.size_error) begin
                    $error("size_error: expected %0d, got %0d",
                           want.size_error, m_data.size_error);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_dim();
        return ($urandom_range(0, 7) == 0) ? DIM : $urandom_range(1, 4);
    endfunction

    task automatic queue_item(logic [1:0] op, int r, int c, logic [31:0] v);
        in_item_t it;
        it.operation = op;
        it.row_index = 3'(r);
        it.col_index = 3'(c);
        it.element_value = v;
        pending_ops.push_back(it);
        if (op == OP_LOAD_A)
            a_written[r][c] = 1'b1;
        else if (op == OP_LOAD_B)
            b_written[r][c] = 1'b1;
        if (op != OP_UNUSED)
            stim_count++;
    endtask

    task automatic queue_compute();
        queue_item(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
    endtask

    // loads every operand entry the compute will read that is still unset,
    // and reloads a share of the rest
    task automatic load_operands(int refresh_pct);
        if (!shape_fits())
            return;
        for (int i = 0; i < cfg_a_rows; i++)
            for (int k = 0; k < cfg_a_cols; k++)
                if (!a_written[i][k] || $urandom_range(0, 99) < refresh_pct)
                    queue_item(OP_LOAD_A, i, k, pick_value());
        for (int k = 0; k < cfg_b_rows; k++)
            for (int j = 0; j < cfg_b_cols; j++)
                if (!b_written[k][j] || $urandom_range(0, 99) < refresh_pct)
                    queue_item(OP_LOAD_B, k, j, pick_value());
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: queue_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
                1: queue_item(OP_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
                default: queue_item(OP_LOAD_B, $urandom_range(0, 7), $urandom_range(0, 7),
                                    pick_value());
            endcase
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_A_ROWS: cfg_a_rows = val;
            REG_A_COLS: cfg_a_cols = val;
            REG_B_ROWS: cfg_b_rows = val;
            REG_B_COLS: cfg_b_cols = val;
            REG_OP_MODE: cfg_op_mode = val[1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int ar, int ac, int br, int bc, logic [1:0] md);
        write_reg(REG_A_ROWS, 4'(ar));
        write_reg(REG_A_COLS, 4'(ac));
        write_reg(REG_B_ROWS, 4'(br));
        write_reg(REG_B_COLS, 4'(bc));
        write_reg(REG_OP_MODE, {2'b00, md});
    endtask

    task automatic set_idle(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // wait until every item is taken and every result has come, then let
    // trailing loads clear the block
    task automatic drain();
        do @(negedge aclk);
        while (pending_ops.size() != 0 || items_taken != items_sent
               || matrix_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        #20_000_000;
        $display("matrix_add_sub_multiply_unit_top: mismatch");
        $finish;
    end

    initial begin
        int ar;
        int ac;
        int br;
        int bc;
        int batches;
        int phase;
        logic [1:0] md;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset shape 1x1 add, wrap on add, writes outside the shape, ignored op
        set_idle(0);
        queue_item(OP_LOAD_A, 0, 0, 32'h7fff_ffff);
        queue_item(OP_LOAD_B, 0, 0, 32'h0000_0001);
        queue_compute();
        queue_item(OP_LOAD_A, 7, 7, 32'h8000_0000);
        queue_item(OP_LOAD_B, 7, 7, 32'hffff_ffff);
        queue_item(OP_UNUSED, 7, 7, 32'hffff_ffff);
        queue_item(OP_COMPUTE, 7, 7, 32'hffff_ffff);
        drain();

        write_reg(REG_OP_MODE, {2'b00, MODE_SUB});
        queue_item(OP_LOAD_A, 0, 0, 32'h8000_0000);
        queue_item(OP_LOAD_B, 0, 0, 32'h0000_0001);
        queue_compute();
        drain();

        write_reg(REG_OP_MODE, {2'b00, MODE_MUL});
        queue_item(OP_LOAD_A, 0, 0, 32'hffff_ffff);
        queue_item(OP_LOAD_B, 0, 0, 32'h8000_0000);
        queue_compute();
        drain();

        // error results: zero and oversize dims, unused mode, shape mismatches
        write_reg(REG_A_ROWS, 4'd0);
        queue_compute();
        drain();
        write_reg(REG_A_ROWS, 4'd1);
        write_reg(REG_A_COLS, 4'd15);
        queue_compute();
        drain();
        write_reg(REG_A_COLS, 4'd1);
        write_reg(REG_OP_MODE, {2'b00, MODE_UNUSED});
        queue_compute();
        drain();
        write_reg(REG_OP_MODE, {2'b00, MODE_ADD});
        write_reg(REG_B_ROWS, 4'd2);
        queue_compute();
        drain();
        write_reg(REG_OP_MODE, {2'b00, MODE_MUL});
        queue_compute();
        drain();
        write_reg(REG_B_ROWS, 4'd1);
        write_reg(REG_B_COLS, 4'd0);
        queue_compute();
        drain();

        // 8x1 * 1x8 while the receiver holds off, so the input backs up
        configure(DIM, 1, 1, DIM, MODE_MUL);
        hold_req++;
        load_operands(0);
        queue_compute();
        load_operands(50);
        queue_compute();
        queue_compute();
        drain();

        set_idle(3);
        configure(1, DIM, DIM, 1, MODE_MUL);
        load_operands(30);
        queue_compute();
        drain();

        set_idle(1);
        configure(DIM, DIM, DIM, DIM, MODE_MUL);
        load_operands(10);
        queue_compute();
        drain();

        phase = 0;
        while (stim_count < ITEM_TARGET) begin
            md = 2'($urandom_range(0, 2));
            ar = rand_dim();
            ac = rand_dim();
            bc = rand_dim();
            if (md == MODE_MUL) begin
                br = ac;
            end else begin
                br = ar;
                bc = ac;
            end
            case ($urandom_range(0, 9))
                0: md = MODE_UNUSED;
                1: ar = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
                2: bc = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
                3: br = br % DIM + 1;
                default: ;
            endcase
            set_idle(phase);
            configure(ar, ac, br, bc, md);
            batches = $urandom_range(1, 3);
            repeat (batches) begin
                if ($urandom_range(0, 2) == 0)
                    add_noise();
                load_operands(35);
                queue_compute();
                if ($urandom_range(0, 4) == 0)
                    queue_compute();
            end
            add_noise();
            drain();
            phase++;
        end

        if (fail_count == 0)
            $display("matrix_add_sub_multiply_unit_top: match");
        else
            $display("matrix_add_sub_multiply_unit_top: mismatch");
        $finish;
    end

endmodule
